// File: rtl/assert_macros.svh
// Assertion macros used by the RTL of the record log scanner.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a property holds at every clock edge outside reset.
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion violated");

// Check that a condition never occurs at a clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");

`endif

// File: rtl/crlsu_pkg.sv
// Types, constants and the CRC-32 byte update of the record log scanner.
package crlsu_pkg;

  localparam int unsigned HDR_BYTES        = 32;
  localparam int unsigned HDR_IDX_W        = 5;
  localparam logic [31:0] LOG_MAGIC        = 32'h314D_4854;
  localparam logic [15:0] LOG_VERSION      = 16'd1;
  localparam logic [31:0] CRC_POLY         = 32'hEDB8_8320;
  localparam logic [31:0] CRC_INIT         = 32'hFFFF_FFFF;
  localparam logic [31:0] CRC_XOR_OUT      = 32'hFFFF_FFFF;
  localparam int unsigned MAX_RECORD_DEF   = 2 * 1024 * 1024;
  localparam int unsigned FILE_LEN_W       = 40;
  localparam int unsigned KEY_W            = 64;
  localparam int unsigned SIZE_OUT_W       = 22;
  localparam int unsigned FLAGS_W          = 16;
  localparam int unsigned ATIME_W          = 64;
  localparam int unsigned OUT_DATA_W       = 248;
  localparam int unsigned RES_DEPTH        = 4;
  // register index, carried on paddr[3]
  localparam logic        REG_FILE_LEN     = 1'b0;

  typedef enum logic {
    KIND_ENTRY  = 1'b0,
    KIND_FINISH = 1'b1
  } result_kind_e;

  typedef struct packed {
    result_kind_e            kind;
    logic [KEY_W-1:0]        key;
    logic [FILE_LEN_W-1:0]   offset;
    logic [SIZE_OUT_W-1:0]   size;
    logic [FLAGS_W-1:0]      flags;
    logic [ATIME_W-1:0]      acc_time;
    logic [FILE_LEN_W-1:0]   valid_len;
    logic                    trunc;
    logic                    last;
  } result_t;

  // Reflected CRC-32 update over one byte, one bit per step.
  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'd0, b};
    for (int i = 0; i < 8; i++) begin
      c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
    end
    return c;
  endfunction

endpackage

// File: rtl/crlsu_rslt_fifo.sv
// Result queue of the record log scanner: up to two writes, one read per cycle.
module crlsu_rslt_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [1:0]          push_n_i,
  input  crlsu_pkg::result_t  push0_i,
  input  crlsu_pkg::result_t  push1_i,
  output logic                room_o,
  output logic                valid_o,
  input  logic                ready_i,
  output crlsu_pkg::result_t  data_o
);
  import crlsu_pkg::*;

  localparam int unsigned PTR_W = $clog2(RES_DEPTH);

  result_t          mem_q [RES_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [PTR_W:0]   cnt_q, cnt_d;
  logic [PTR_W-1:0] wr_ptr_nx;
  logic             pop;

  assign pop       = valid_o & ready_i;
  assign wr_ptr_nx = wr_ptr_q + PTR_W'(1);
  assign wr_ptr_d  = wr_ptr_q + PTR_W'(push_n_i);
  assign rd_ptr_d  = rd_ptr_q + PTR_W'(pop);
  assign cnt_d     = cnt_q + (PTR_W+1)'(push_n_i) - (PTR_W+1)'(pop);

  assign valid_o = cnt_q != '0;
  assign data_o  = mem_q[rd_ptr_q];
  // Accept a byte only while two slots are free.
  assign room_o  = cnt_q <= (PTR_W+1)'(RES_DEPTH - 2);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_n_i != 2'd0) begin
      mem_q[wr_ptr_q] <= push0_i;
    end
    if (push_n_i == 2'd2) begin
      mem_q[wr_ptr_nx] <= push1_i;
    end
  end

endmodule

// File: rtl/crc_record_log_scanner_unit.sv
// Record log scanner: header check, payload CRC-32 and index entry output.
//
// Usage: the log streams in one byte per slave transaction (tdata = byte,
// tuser = first byte of a new scan). Each record is a 32-byte little-endian
// header plus payload. Every good record yields an index entry on the master
// side (tuser 0); the first bad or short record, or a log fully covered by
// good records, yields a finish result (tuser 1) with the valid length and
// the truncate flag. tlast marks the last result caused by one byte.
// file_length is to be written over the APB port only while the scanner is
// idle; the block itself does not enforce this. Throughput: one byte per
// cycle while the result queue has room. The scan state, the header fields
// and the CRC-32 byte update are handled combinationally between the state
// registers; a result is written into a 4-entry queue as its byte is taken.
// s_axis_tready drops while fewer than two slots are free, so a stalled
// receiver stalls the input once three results are queued. Reset clears the
// scan to byte 0 of the log, clears file_length and empties the queue.
`include "assert_macros.svh"

module crc_record_log_scanner_unit #(
  parameter int unsigned MAX_RECORD_BYTES = crlsu_pkg::MAX_RECORD_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  // APB configuration port
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [3:0]   paddr,
  input  logic [63:0]  pwdata,
  output logic [63:0]  prdata,
  output logic         pready,
  // log byte input
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  input  logic [7:0]   s_axis_tdata_i,  // [7:0] data_byte
  input  logic         s_axis_tuser_i,  // [0] first_byte
  // result output
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // [63:0] entry_key, [103:64] entry_offset, [125:104] stored_size,
  // [141:126] entry_flags, [205:142] access_time, [245:206] valid_length,
  // [246] needs_truncate, [247] zero
  output logic [crlsu_pkg::OUT_DATA_W-1:0] m_axis_tdata_o,
  output logic         m_axis_tuser_o,  // [0] result_kind
  output logic         m_axis_tlast_o   // last_of_run
);
  import crlsu_pkg::*;

  localparam int unsigned CNT_RAW = $clog2(MAX_RECORD_BYTES + 1);
  localparam int unsigned CNT_W   = (CNT_RAW > HDR_IDX_W + 1) ? CNT_RAW : HDR_IDX_W + 1;
  localparam int unsigned END_W   = FILE_LEN_W + 2;

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_PAYLOAD = 2'd1,
    PH_DONE    = 2'd2
  } phase_e;

  // configuration
  logic [FILE_LEN_W-1:0] file_len_q;
  logic                  cfg_wr;

  // scan state
  phase_e                phase_q, phase_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic [FILE_LEN_W-1:0] start_q, start_d;
  logic [31:0]           crc_q, crc_d;
  logic [END_W-1:0]      end_q;

  // header words
  logic [31:0]           magic_q;
  logic [15:0]           version_q;
  logic [15:0]           flags_q;
  logic [KEY_W-1:0]      key_q;
  logic [ATIME_W-1:0]    atime_q;
  logic [31:0]           size_q;
  logic [31:0]           crcw_q;

  logic                  s_acc;
  logic                  first;
  phase_e                phase_eff;
  logic [CNT_W-1:0]      cnt_eff;
  logic [CNT_W-1:0]      cnt_inc;
  logic [FILE_LEN_W-1:0] start_eff;
  logic [FILE_LEN_W:0]   start_hdr;
  logic                  at_eof;
  logic                  hdr_short;
  logic                  hdr_first;
  logic [HDR_IDX_W-1:0]  hdr_idx;
  logic                  hdr_ok;
  logic                  hdr_we;
  logic [31:0]           crc_nxt;
  logic                  pay_last;
  logic                  crc_good;
  logic [FILE_LEN_W-1:0] next_start;
  logic                  run_end;

  logic [1:0]            push_n;
  result_t               res0, res1, rslt_out;
  logic                  fifo_room;

  function automatic result_t mk_finish(input logic [FILE_LEN_W-1:0] valid,
                                        input logic [FILE_LEN_W-1:0] flen);
    result_t r;
    r           = '0;
    r.kind      = KIND_FINISH;
    r.valid_len = valid;
    r.trunc     = valid != flen;
    r.last      = 1'b1;
    return r;
  endfunction

  // ---------------------------------------------------------------- APB
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;
  assign prdata = (paddr[3] == REG_FILE_LEN) ? {24'd0, file_len_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      file_len_q <= '0;
    end else if (cfg_wr && paddr[3] == REG_FILE_LEN) begin
      file_len_q <= pwdata[FILE_LEN_W-1:0];
    end
  end

  // ---------------------------------------------------------------- scan
  assign s_axis_tready_o = fifo_room;
  assign s_acc           = s_axis_tvalid_i & s_axis_tready_o;
  assign first           = s_axis_tuser_i;

  // A first byte restarts the scan before the byte is taken.
  assign phase_eff = first ? PH_HEADER : phase_q;
  assign cnt_eff   = first ? '0 : cnt_q;
  assign start_eff = first ? '0 : start_q;
  assign cnt_inc   = cnt_eff + CNT_W'(1);

  assign start_hdr = {1'b0, start_eff} + (FILE_LEN_W+1)'(HDR_BYTES);
  assign at_eof    = file_len_q <= start_eff;
  assign hdr_short = {1'b0, file_len_q} < start_hdr;
  assign hdr_first = cnt_eff == '0;
  assign hdr_idx   = cnt_eff[HDR_IDX_W-1:0];

  // end_q settles well before the last header byte arrives.
  assign hdr_ok = (magic_q == LOG_MAGIC) && (version_q == LOG_VERSION) &&
                  (size_q != '0) && (size_q <= 32'(MAX_RECORD_BYTES)) &&
                  !hdr_short && (end_q <= {2'b00, file_len_q});

  assign crc_nxt    = crc_byte(crc_q, s_axis_tdata_i);
  assign pay_last   = 32'(cnt_inc) == size_q;
  assign crc_good   = (crc_nxt ^ CRC_XOR_OUT) == crcw_q;
  assign next_start = end_q[FILE_LEN_W-1:0];
  assign run_end    = next_start >= file_len_q;

  always_comb begin
    phase_d = phase_q;
    cnt_d   = cnt_q;
    start_d = start_q;
    crc_d   = crc_q;
    hdr_we  = 1'b0;
    push_n  = 2'd0;
    res0    = '0;
    res1    = '0;
    if (s_acc) begin
      phase_d = phase_eff;
      cnt_d   = cnt_eff;
      start_d = start_eff;
      if (first) begin
        crc_d = CRC_INIT;
      end
      unique case (phase_eff)
        PH_HEADER: begin
          if (hdr_first && at_eof) begin
            // nothing left in the log: drop the byte
          end else if (hdr_first && hdr_short) begin
            res0    = mk_finish(start_eff, file_len_q);
            push_n  = 2'd1;
            phase_d = PH_DONE;
          end else begin
            hdr_we = 1'b1;
            cnt_d  = cnt_inc;
            if (hdr_idx == HDR_IDX_W'(HDR_BYTES - 1)) begin
              if (!hdr_ok) begin
                res0    = mk_finish(start_eff, file_len_q);
                push_n  = 2'd1;
                phase_d = PH_DONE;
              end else begin
                phase_d = PH_PAYLOAD;
                cnt_d   = '0;
                crc_d   = CRC_INIT;
              end
            end
          end
        end
        PH_PAYLOAD: begin
          crc_d = crc_nxt;
          cnt_d = cnt_inc;
          if (pay_last) begin
            if (!crc_good) begin
              res0    = mk_finish(start_eff, file_len_q);
              push_n  = 2'd1;
              phase_d = PH_DONE;
            end else begin
              res0.kind     = KIND_ENTRY;
              res0.key      = key_q;
              res0.offset   = start_eff;
              res0.size     = size_q[SIZE_OUT_W-1:0];
              res0.flags    = flags_q;
              res0.acc_time = atime_q;
              res0.last     = !run_end;
              push_n        = 2'd1;
              start_d       = next_start;
              phase_d       = PH_HEADER;
              cnt_d         = '0;
              crc_d         = CRC_INIT;
              if (run_end) begin
                res1    = mk_finish(next_start, file_len_q);
                push_n  = 2'd2;
                phase_d = PH_DONE;
              end
            end
          end
        end
        PH_DONE: begin
          // hold until the next first byte
        end
        default: begin
          phase_d = PH_DONE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HEADER;
      cnt_q   <= '0;
      start_q <= '0;
      crc_q   <= CRC_INIT;
    end else begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      start_q <= start_d;
      crc_q   <= crc_d;
    end
  end

  // Header capture, one byte lane per header byte index.
  always_ff @(posedge clk_i) begin
    end_q <= {2'b00, start_q} + END_W'(HDR_BYTES) + END_W'(size_q);
    if (hdr_we) begin
      unique case (hdr_idx[4:2])
        3'd0: magic_q[{hdr_idx[1:0], 3'b000} +: 8] <= s_axis_tdata_i;
        3'd1: begin
          if (!hdr_idx[1]) begin
            version_q[{hdr_idx[0], 3'b000} +: 8] <= s_axis_tdata_i;
          end else begin
            flags_q[{hdr_idx[0], 3'b000} +: 8] <= s_axis_tdata_i;
          end
        end
        3'd2, 3'd3: key_q[{hdr_idx[2:0], 3'b000} +: 8] <= s_axis_tdata_i;
        3'd4, 3'd5: atime_q[{hdr_idx[2:0], 3'b000} +: 8] <= s_axis_tdata_i;
        3'd6: size_q[{hdr_idx[1:0], 3'b000} +: 8] <= s_axis_tdata_i;
        3'd7: crcw_q[{hdr_idx[1:0], 3'b000} +: 8] <= s_axis_tdata_i;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- output
  crlsu_rslt_fifo u_rslt_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_n_i (push_n),
    .push0_i  (res0),
    .push1_i  (res1),
    .room_o   (fifo_room),
    .valid_o  (m_axis_tvalid_o),
    .ready_i  (m_axis_tready_i),
    .data_o   (rslt_out)
  );

  assign m_axis_tdata_o = {1'b0, rslt_out.trunc, rslt_out.valid_len, rslt_out.acc_time,
                           rslt_out.flags, rslt_out.size, rslt_out.offset, rslt_out.key};
  assign m_axis_tuser_o = rslt_out.kind;
  assign m_axis_tlast_o = rslt_out.last;

  // ---------------------------------------------------------------- checks
  `ASSERT_PROP(a_finish_is_last, clk_i, rst_ni,
    (m_axis_tvalid_o && rslt_out.kind == KIND_FINISH) |-> rslt_out.last)
  `ASSERT_NEVER(a_entry_no_length, clk_i, rst_ni,
    m_axis_tvalid_o && rslt_out.kind == KIND_ENTRY && (rslt_out.valid_len != '0 || rslt_out.trunc))
  `ASSERT_PROP(a_payload_cnt_below_size, clk_i, rst_ni,
    (phase_q == PH_PAYLOAD) |-> (32'(cnt_q) < size_q))

endmodule

// File: dv/tb.sv
// Self-checking testbench for the record log scanner: byte stream in, index results out.
module tb;
  import crlsu_pkg::*;

  localparam int unsigned CYCLE_LIMIT     = 2_000_000;
  localparam int unsigned TOTAL_BYTES     = 1750;
  localparam logic [39:0] LEN_MAX         = 40'hFF_FFFF_FFFF;

  typedef enum logic [1:0] {
    SCAN_HDR,
    SCAN_PAYLOAD,
    SCAN_DONE
  } scan_phase_e;

  typedef enum int unsigned {
    FAULT_MAGIC,
    FAULT_VERSION,
    FAULT_ZERO_SIZE,
    FAULT_HUGE_SIZE,
    FAULT_CRC
  } rec_fault_e;

  typedef struct packed {
    logic [7:0] data;
    logic       first;
  } log_byte_t;

  logic         clk_i           = 1'b0;
  logic         rst_ni          = 1'b0;
  logic         psel            = 1'b0;
  logic         penable         = 1'b0;
  logic         pwrite          = 1'b0;
  logic [3:0]   paddr           = '0;
  logic [63:0]  pwdata          = '0;
  logic [63:0]  prdata;
  logic         pready;
  logic         s_axis_tvalid_i = 1'b0;
  logic         s_axis_tready_o;
  logic [7:0]   s_axis_tdata_i  = '0;  // [7:0] data_byte
  logic         s_axis_tuser_i  = 1'b0;  // [0] first_byte
  logic         m_axis_tvalid_o;
  logic         m_axis_tready_i = 1'b0;
  // [63:0] entry_key, [103:64] entry_offset, [125:104] stored_size,
  // [141:126] entry_flags, [205:142] access_time, [245:206] valid_length,
  // [246] needs_truncate, [247] zero
  logic [OUT_DATA_W-1:0] m_axis_tdata_o;
  logic         m_axis_tuser_o;  // [0] result_kind
  logic         m_axis_tlast_o;

  crc_record_log_scanner_unit u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // scanner shadow state
  scan_phase_e  scan_ph      = SCAN_HDR;
  int unsigned  hdr_cnt      = 0;
  int unsigned  pay_cnt      = 0;
  logic [39:0]  rec_start    = '0;
  logic [39:0]  file_len_cfg = '0;
  logic [255:0] hdr_img      = '0;
  logic [31:0]  pay_crc      = CRC_INIT;

  log_byte_t    log_bytes_q[$];
  result_t      index_results_q[$];
  logic [7:0]   log_image[$];

  int unsigned  bytes_scanned = 0;
  int unsigned  results_seen  = 0;
  int unsigned  mismatch_cnt  = 0;
  int unsigned  cycle_cnt     = 0;
  int unsigned  send_gap      = 0;
  int unsigned  send_calm     = 0;
  int unsigned  take_gap      = 0;
  int unsigned  take_calm     = 0;
  log_byte_t    next_byte;

  function automatic logic [31:0] crc32_step(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] r;
    r = c;
    for (int i = 0; i < 8; i++) begin
      if (r[0] ^ b[i]) r = (r >> 1) ^ CRC_POLY;
      else r = r >> 1;
    end
    return r;
  endfunction

  function automatic int unsigned pick_gap(inout int unsigned calm);
    int unsigned r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 2) begin
      calm = $urandom_range(30, 200);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  task automatic restart_scan();
    scan_ph   = SCAN_HDR;
    hdr_cnt   = 0;
    pay_cnt   = 0;
    rec_start = '0;
    hdr_img   = '0;
    pay_crc   = CRC_INIT;
  endtask

  function automatic logic [39:0] log_bytes_left();
    return (file_len_cfg > rec_start) ? file_len_cfg - rec_start : 40'd0;
  endfunction

  task automatic push_finish();
    result_t r;
    r           = '0;
    r.kind      = KIND_FINISH;
    r.valid_len = rec_start;
    r.trunc     = (rec_start != file_len_cfg);
    r.last      = 1'b1;
    index_results_q.push_back(r);
    scan_ph = SCAN_DONE;
  endtask

  // Advance the shadow scanner by one accepted log byte.
  task automatic scan_log_byte(input logic [7:0] b, input logic first);
    result_t     r;
    logic [39:0] left;
    logic [31:0] sz;
    bit          ok;
    if (first) restart_scan();
    if (scan_ph == SCAN_DONE) return;
    sz = hdr_img[223:192];
    if (scan_ph == SCAN_HDR) begin
      left = log_bytes_left();
      if (hdr_cnt == 0) begin
        if (left == 0) return;
        if (left < HDR_BYTES) begin
          push_finish();
          return;
        end
        hdr_img = '0;
      end
      hdr_img[8*hdr_cnt +: 8] = b;
      hdr_cnt++;
      if (hdr_cnt == HDR_BYTES) begin
        sz = hdr_img[223:192];
        ok = hdr_img[31:0] == LOG_MAGIC && hdr_img[47:32] == LOG_VERSION &&
             sz != 0 && sz <= MAX_RECORD_DEF && left >= HDR_BYTES &&
             {8'd0, sz} <= left - 40'(HDR_BYTES);
        if (!ok) begin
          push_finish();
          return;
        end
        scan_ph = SCAN_PAYLOAD;
        hdr_cnt = 0;
        pay_cnt = 0;
        pay_crc = CRC_INIT;
      end
      return;
    end
    pay_crc = crc32_step(pay_crc, b);
    pay_cnt++;
    if (pay_cnt < sz) return;
    if ((pay_crc ^ CRC_XOR_OUT) != hdr_img[255:224]) begin
      push_finish();
      return;
    end
    r          = '0;
    r.kind     = KIND_ENTRY;
    r.key      = hdr_img[127:64];
    r.offset   = rec_start;
    r.size     = sz[21:0];
    r.flags    = hdr_img[63:48];
    r.acc_time = hdr_img[191:128];
    r.last     = 1'b1;
    rec_start  = rec_start + 40'(HDR_BYTES) + 40'(sz);
    scan_ph    = SCAN_HDR;
    pay_cnt    = 0;
    pay_crc    = CRC_INIT;
    if (rec_start >= file_len_cfg) begin
      r.last = 1'b0;
      index_results_q.push_back(r);
      push_finish();
    end else begin
      index_results_q.push_back(r);
    end
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    mismatch_cnt++;
    if (mismatch_cnt <= 40)
      $display("mismatch on %0s at result %0d: got %0h, want %0h",
               what, results_seen, got, want);
  endtask

  task automatic compare_index_result();
    result_t               want;
    logic [OUT_DATA_W-1:0] d;
    d = m_axis_tdata_o;
    results_seen++;
    if (index_results_q.size() == 0) begin
      report_mismatch("result with nothing pending", 64'(m_axis_tuser_o), 64'd0);
      return;
    end
    want = index_results_q.pop_front();
    if (m_axis_tuser_o !== want.kind)
      report_mismatch("result_kind", 64'(m_axis_tuser_o), 64'(want.kind));
    if (d[63:0] !== want.key) report_mismatch("entry_key", d[63:0], want.key);
    if (d[103:64] !== want.offset)
      report_mismatch("entry_offset", 64'(d[103:64]), 64'(want.offset));
    if (d[125:104] !== want.size)
      report_mismatch("stored_size", 64'(d[125:104]), 64'(want.size));
    if (d[141:126] !== want.flags)
      report_mismatch("entry_flags", 64'(d[141:126]), 64'(want.flags));
    if (d[205:142] !== want.acc_time)
      report_mismatch("access_time", d[205:142], want.acc_time);
    if (d[245:206] !== want.valid_len)
      report_mismatch("valid_length", 64'(d[245:206]), 64'(want.valid_len));
    if (d[246] !== want.trunc)
      report_mismatch("needs_truncate", 64'(d[246]), 64'(want.trunc));
    if (m_axis_tlast_o !== want.last)
      report_mismatch("last_of_run", 64'(m_axis_tlast_o), 64'(want.last));
  endtask

  // byte driver: one transaction per log byte, random gaps in between
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid_i <= 1'b0;
      restart_scan();
      file_len_cfg = '0;
    end else begin
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        scan_log_byte(s_axis_tdata_i, s_axis_tuser_i);
        bytes_scanned++;
      end
      if (!s_axis_tvalid_i || s_axis_tready_o) begin
        if (send_gap > 0) begin
          send_gap--;
          s_axis_tvalid_i <= 1'b0;
        end else if (log_bytes_q.size() != 0) begin
          next_byte = log_bytes_q.pop_front();
          s_axis_tdata_i  <= next_byte.data;
          s_axis_tuser_i  <= next_byte.first;
          s_axis_tvalid_i <= 1'b1;
          send_gap = pick_gap(send_calm);
        end else begin
          s_axis_tvalid_i <= 1'b0;
        end
      end
    end
  end

  // result monitor with random back-pressure
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
    end else begin
      if (m_axis_tvalid_o && m_axis_tready_i) compare_index_result();
      if (take_gap > 0) begin
        take_gap--;
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= 1'b1;
        take_gap = pick_gap(take_calm);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("crc_record_log_scanner_unit regression: fail");
      $finish;
    end
  end

  // Hold until every byte is taken and every result is out, then let the pipe settle.
  task automatic wait_scanner_idle();
    while (log_bytes_q.size() != 0 || s_axis_tvalid_i || index_results_q.size() != 0)
      @(negedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic set_file_length(input logic [39:0] len);
    wait_scanner_idle();
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_FILE_LEN, 3'b000};
    pwdata  <= {24'd0, len};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    file_len_cfg = len;
  endtask

  task automatic send_log(input bit restart);
    log_byte_t item;
    foreach (log_image[i]) begin
      item.data  = log_image[i];
      item.first = restart && (i == 0);
      log_bytes_q.push_back(item);
    end
    log_image.delete();
  endtask

  task automatic append_noise(input int unsigned n);
    repeat (n) log_image.push_back(8'($urandom));
  endtask

  task automatic append_record(input logic [63:0] key, input logic [15:0] flags,
                               input logic [63:0] atime, input logic [31:0] magic,
                               input logic [15:0] ver, input logic [31:0] size_f,
                               input int unsigned pay_len, input logic [31:0] crc_flip);
    logic [255:0] hdr;
    logic [7:0]   payload[$];
    logic [31:0]  crc;
    logic [7:0]   b;
    crc = CRC_INIT;
    repeat (pay_len) begin
      b = 8'($urandom);
      payload.push_back(b);
      crc = crc32_step(crc, b);
    end
    hdr = {(crc ^ CRC_XOR_OUT) ^ crc_flip, size_f, atime, key, flags, ver, magic};
    for (int i = 0; i < HDR_BYTES; i++) log_image.push_back(hdr[8*i +: 8]);
    foreach (payload[i]) log_image.push_back(payload[i]);
  endtask

  task automatic append_good(input int unsigned sz);
    append_record({$urandom, $urandom}, 16'($urandom), {$urandom, $urandom},
                  LOG_MAGIC, LOG_VERSION, sz, sz, 32'd0);
  endtask

  task automatic append_faulty(input int unsigned sz, input rec_fault_e fault);
    logic [31:0] magic;
    logic [31:0] size_f;
    logic [31:0] crc_flip;
    logic [15:0] ver;
    magic    = LOG_MAGIC;
    ver      = LOG_VERSION;
    size_f   = sz;
    crc_flip = '0;
    case (fault)
      FAULT_MAGIC:     magic = magic ^ (32'd1 << $urandom_range(0, 31));
      FAULT_VERSION: begin
        ver = 16'($urandom);
        if (ver == LOG_VERSION) ver = 16'hFFFF;
      end
      FAULT_ZERO_SIZE: size_f = '0;
      FAULT_HUGE_SIZE: size_f = $urandom_range(MAX_RECORD_DEF + 1, 32'hFFFF_FFFF);
      default: begin
        crc_flip = 32'($urandom);
        if (crc_flip == 0) crc_flip = 32'h8000_0000;
      end
    endcase
    append_record({$urandom, $urandom}, 16'($urandom), {$urandom, $urandom},
                  magic, ver, size_f, sz, crc_flip);
  endtask

  function automatic int unsigned pick_payload_size();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 16);
    if (r < 95) return $urandom_range(17, 120);
    return $urandom_range(121, 700);
  endfunction

  // Build one log, set its length, then stream it.
  task automatic random_log();
    int unsigned n_rec;
    int unsigned sz;
    int unsigned k;
    int unsigned r;
    logic [39:0] covered;
    logic [39:0] len;
    bit          restart;
    covered = '0;
    restart = ($urandom_range(0, 19) != 0);
    r = $urandom_range(0, 99);
    if (r < 5) begin
      append_noise($urandom_range(1, 40));
      len = 40'($urandom_range(0, 80));
    end else begin
      n_rec = $urandom_range(1, 4);
      repeat (n_rec) begin
        sz = pick_payload_size();
        append_good(sz);
        covered += 40'(HDR_BYTES + sz);
      end
      r = $urandom_range(0, 99);
      if (r < 30) begin
        len = covered;
      end else if (r < 45) begin
        k = $urandom_range(1, HDR_BYTES - 1);
        append_noise(k);
        len = covered + 40'(k);
      end else if (r < 70) begin
        sz = pick_payload_size();
        append_faulty(sz, rec_fault_e'($urandom_range(0, 4)));
        len = covered + 40'(HDR_BYTES + sz + $urandom_range(0, 40));
      end else if (r < 80) begin
        // record one to all of its payload bytes too long for the log
        sz = pick_payload_size();
        k = $urandom_range(1, sz);
        append_good(sz);
        len = covered + 40'(HDR_BYTES + sz - k);
      end else if (r < 92) begin
        append_noise($urandom_range(0, 40));
        len = covered + 40'($urandom_range(100, 5000));
      end else begin
        len = {8'($urandom), 32'($urandom)};
      end
      if ($urandom_range(0, 3) == 0) append_noise($urandom_range(1, 8));
    end
    set_file_length(len);
    send_log(restart);
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // zero-length log: nothing is scanned, with or without first_byte
    append_noise(3);
    send_log(1'b0);
    append_noise(1);
    send_log(1'b1);

    // single record filling the log exactly, started without first_byte
    set_file_length(40'd33);
    append_record('1, '1, '1, LOG_MAGIC, LOG_VERSION, 32'd1, 1, 32'd0);
    send_log(1'b0);
    append_noise(2);
    send_log(1'b0);

    // log shorter than one header
    set_file_length(40'd20);
    append_noise(5);
    send_log(1'b1);

    // each header fault and a payload CRC error behind a good record
    set_file_length(LEN_MAX);
    for (int f = FAULT_MAGIC; f <= FAULT_CRC; f++) begin
      append_record('0, '0, '0, LOG_MAGIC, LOG_VERSION, 32'd2, 2, 32'd0);
      append_faulty(3, rec_fault_e'(f));
      send_log(1'b1);
    end

    // largest payload size is accepted; abandon the record after a few bytes
    append_record({$urandom, $urandom}, 16'h0001, {$urandom, $urandom},
                  LOG_MAGIC, LOG_VERSION, MAX_RECORD_DEF, 40, 32'd0);
    send_log(1'b1);

    // second record one byte too long for the log
    set_file_length(40'd71);
    append_good(5);
    append_good(3);
    send_log(1'b1);

    // log shrinks below the next record start in the middle of a header
    set_file_length(40'd1000);
    append_good(4);
    append_good(6);
    for (int i = 0; i < 10; i++) log_bytes_q.push_back('{data: log_image[i], first: i == 0});
    log_image = log_image[10:$];
    set_file_length(40'd20);
    send_log(1'b0);

    // log shrinks to end exactly at the record being read
    set_file_length(40'd1000);
    append_good(8);
    for (int i = 0; i < 37; i++) log_bytes_q.push_back('{data: log_image[i], first: i == 0});
    log_image = log_image[37:$];
    set_file_length(40'd40);
    send_log(1'b0);

    while (bytes_scanned + log_bytes_q.size() < TOTAL_BYTES) random_log();

    wait_scanner_idle();
    if (mismatch_cnt == 0) begin
      $display("crc_record_log_scanner_unit regression: pass");
    end else begin
      $display("crc_record_log_scanner_unit regression: fail");
    end
    $finish;
  end

endmodule
